### rtl/knn_weighted_row_mean_unit_macros.svh
// assertion helpers for the smoothing unit
`ifndef KNN_WEIGHTED_ROW_MEAN_UNIT_MACROS_SVH
`define KNN_WEIGHTED_ROW_MEAN_UNIT_MACROS_SVH

`define KWM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/kwm_pkg.sv
`default_nettype none
package kwm_pkg;
  localparam int CELLS = 1024;
  localparam int GENES = 32;
  localparam int CELL_W = 10;
  localparam int GENE_W = 5;
  localparam int GCNT_W = 6;
  localparam int ADDR_W = CELL_W + GENE_W;
  localparam int ACC_W = 56;
  localparam int TOT_W = 24;
  localparam int W_W = 18;
  localparam logic [W_W-1:0] WEIGHT_ONE = 18'd65536;
  localparam logic [W_W-1:0] WEIGHT_MAX = 18'd131072;
  localparam logic [1:0] REG_WEIGHT_EN = 2'd0;
  localparam logic [1:0] REG_CELLS = 2'd1;
  localparam logic [1:0] REG_GENES = 2'd2;

  typedef struct packed {
    logic start;
    logic [ACC_W-1:0] num;
    logic [TOT_W-1:0] den;
  } div_req_t;
endpackage
`default_nettype wire

### rtl/knn_weighted_row_mean_unit.sv
`default_nettype none
// channel | direction | fields
// in      | input     | req_type load_cell load_gene expr_value target_cell
//         |           | neighbor_index neighbor_weight last_neighbor
// out     | output    | out_cell out_gene mean_value last_gene
// cfg     | APB       | weight_en cells_in_use genes_in_use
// A load word goes straight into the store. A neighbor word stalls in while
// the genes in use are run: one store read a cycle, then multiply, then add.
// A last neighbor then runs the divider once per gene, giving one result
// word per gene. rst is synchronous; per-gene valid bits make the
// accumulators read as zero until written.
// A stall on out holds the result word and keeps in stalled.
`include "knn_weighted_row_mean_unit_macros.svh"
module knn_weighted_row_mean_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [9:0]  load_cell,
  input  wire logic [4:0]  load_gene,
  input  wire logic [31:0] expr_value,
  input  wire logic [9:0]  target_cell,
  input  wire logic [15:0] neighbor_index,
  input  wire logic [17:0] neighbor_weight,
  input  wire logic        last_neighbor,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_cell,
  output logic [4:0]       out_gene,
  output logic [31:0]      mean_value,
  output logic             last_gene
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic weight_en;
  logic [10:0] cells_in_use;
  logic [5:0] genes_in_use;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_en <= 1'b0;
      cells_in_use <= 11'd1024;
      genes_in_use <= 6'd32;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        kwm_pkg::REG_WEIGHT_EN: weight_en <= pwdata[0];
        kwm_pkg::REG_CELLS: cells_in_use <= pwdata[10:0];
        kwm_pkg::REG_GENES: genes_in_use <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kwm_pkg::REG_WEIGHT_EN: prdata = {31'd0, weight_en};
      kwm_pkg::REG_CELLS: prdata = {21'd0, cells_in_use};
      kwm_pkg::REG_GENES: prdata = {26'd0, genes_in_use};
      default: prdata = '0;
    endcase
  end

  logic [kwm_pkg::GCNT_W-1:0] ng;
  always_comb begin
    if (genes_in_use == '0) ng = 6'd1;
    else if (genes_in_use > 6'(kwm_pkg::GENES)) ng = 6'(kwm_pkg::GENES);
    else ng = genes_in_use;
  end
  logic [10:0] climit;
  assign climit = (cells_in_use > 11'(kwm_pkg::CELLS)) ? 11'(kwm_pkg::CELLS) : cells_in_use;

  logic [2:0] state;
  logic [kwm_pkg::GCNT_W-1:0] gcnt;
  logic [kwm_pkg::CELL_W-1:0] row;
  logic [kwm_pkg::W_W-1:0] wt;
  logic [kwm_pkg::TOT_W-1:0] total;
  logic last_q;
  logic [kwm_pkg::CELL_W-1:0] tcell;
  logic rd_v, mul_v;
  logic [kwm_pkg::GENE_W-1:0] rd_g, mul_g;

  logic accept;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  logic [kwm_pkg::W_W-1:0] w_in;
  always_comb begin
    w_in = (neighbor_weight > kwm_pkg::WEIGHT_MAX) ? kwm_pkg::WEIGHT_MAX : neighbor_weight;
    if (!weight_en) w_in = kwm_pkg::WEIGHT_ONE;
  end
  logic idx_ok;
  assign idx_ok = (neighbor_index != 16'd0) && ({5'd0, climit} >= neighbor_index);

  // expression store
  logic st_we;
  logic [kwm_pkg::ADDR_W-1:0] st_raddr;
  logic [31:0] st_rdata;
  assign st_we = accept && !req_type;
  assign st_raddr = {row, gcnt[kwm_pkg::GENE_W-1:0]};
  kwm_ram #(.AW(kwm_pkg::ADDR_W), .DW(32)) u_store (
    .clk(clk), .we(st_we), .waddr({load_cell, load_gene}), .wdata(expr_value),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // accumulator memory: read port addressed by gene, registered read
  logic [kwm_pkg::ACC_W-1:0] acc_mem [kwm_pkg::GENES];
  logic [kwm_pkg::ACC_W-1:0] acc_rd;
  logic [kwm_pkg::GENE_W-1:0] acc_raddr;
  logic acc_we;
  logic [kwm_pkg::GENE_W-1:0] acc_waddr;
  logic [kwm_pkg::ACC_W-1:0] acc_wdata;
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd <= acc_mem[acc_raddr];
  end

  logic [49:0] prod;
  logic [kwm_pkg::ACC_W:0] sum;
  always_ff @(posedge clk) prod <= st_rdata * wt;
  assign sum = {1'b0, acc_rd} + {7'd0, prod};

  kwm_pkg::div_req_t dreq;
  logic dbusy, ddone;
  logic [31:0] dquot;
  kwm_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .done(ddone), .quot(dquot));

  // an accumulator counts as zero until written after reset or after a row is emitted
  logic [kwm_pkg::GENES-1:0] acc_vld;

  always_comb begin
    acc_raddr = rd_g;
    if (state == S_DIV) acc_raddr = gcnt[kwm_pkg::GENE_W-1:0];
    acc_we = mul_v;
    acc_waddr = mul_g;
    acc_wdata = sum[kwm_pkg::ACC_W] ? {kwm_pkg::ACC_W{1'b1}} : sum[kwm_pkg::ACC_W-1:0];
    if (!acc_vld[mul_g]) acc_wdata = {6'd0, prod};
  end

  logic [kwm_pkg::ACC_W-1:0] acc_eff;
  logic div_go;
  assign acc_eff = acc_vld[rd_g] ? acc_rd : '0;
  assign dreq.start = div_go;
  assign dreq.num = acc_eff;
  assign dreq.den = total;

  logic [kwm_pkg::TOT_W:0] tsum;
  assign tsum = {1'b0, total} + {7'd0, w_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      mul_v <= 1'b0;
      total <= '0;
      acc_vld <= '0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      rd_v <= 1'b0;
      mul_v <= rd_v;
      mul_g <= rd_g;
      if (mul_v) acc_vld[mul_g] <= 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && req_type) begin
            tcell <= target_cell;
            last_q <= last_neighbor;
            wt <= w_in;
            row <= 10'(neighbor_index - 16'd1);
            gcnt <= '0;
            if (idx_ok) begin
              total <= tsum[kwm_pkg::TOT_W] ? {kwm_pkg::TOT_W{1'b1}} : tsum[kwm_pkg::TOT_W-1:0];
              state <= S_ACC;
            end else if (last_neighbor) begin
              state <= S_DIV;
            end
          end
        end
        S_ACC: begin
          // one gene per cycle: read the store, multiply while the accumulator
          // is read, then add and write back
          if (gcnt < ng) begin
            rd_v <= 1'b1;
            rd_g <= gcnt[kwm_pkg::GENE_W-1:0];
            gcnt <= gcnt + 6'd1;
          end else if (!rd_v && !mul_v) begin
            gcnt <= '0;
            state <= last_q ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          rd_g <= gcnt[kwm_pkg::GENE_W-1:0];
          state <= S_WAIT;
          div_go <= 1'b0;
        end
        S_WAIT: begin
          if (!dbusy && !ddone && !div_go && !out_valid) begin
            div_go <= 1'b1;
            gcnt <= gcnt + 6'd1;
          end
          if (ddone) begin
            out_valid <= 1'b1;
            out_cell <= tcell;
            out_gene <= 5'(gcnt - 6'd1);
            mean_value <= dquot;
            last_gene <= (gcnt == ng);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (last_gene) begin
              total <= '0;
              acc_vld <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KWM_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `KWM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(mean_value))
  `KWM_ASSERT_IMPL(a_div_idle_start, clk, rst, div_go, !dbusy)
endmodule
`default_nettype wire

### rtl/kwm_ram.sv
`default_nettype none
module kwm_ram #(
  parameter int AW = 15,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/kwm_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, saturated to 32 bits
module kwm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kwm_pkg::div_req_t req,
  output logic                   busy,
  output logic                   done,
  output logic [31:0]            quot
);
  localparam int N = kwm_pkg::ACC_W;
  logic [N-1:0] q;
  logic [kwm_pkg::TOT_W:0] rem;
  logic [kwm_pkg::TOT_W-1:0] den;
  logic [5:0] cnt;
  logic [kwm_pkg::TOT_W:0] trial;
  logic [kwm_pkg::TOT_W:0] shifted;
  logic zero;

  assign shifted = {rem[kwm_pkg::TOT_W-1:0], q[N-1]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 6'(N - 1);
        zero <= (req.den == '0);
      end else if (busy) begin
        if (!trial[kwm_pkg::TOT_W]) begin
          rem <= trial;
          q <= {q[N-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q <= {q[N-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  assign quot = zero ? 32'd0 : ((|q[N-1:32]) ? 32'hFFFF_FFFF : q[31:0]);
endmodule
`default_nettype wire
